### hdl/sdff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdff_pkg: shared definitions for the signed decimal field formatter
// Constants, character codes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package sdff_pkg;

  localparam int MAX_FIELD  = 62;
  localparam int VALUE_BITS = 32;
  // decimal digits of the largest magnitude, 2**(VALUE_BITS-1)
  localparam int DIGITS     = 10;
  localparam int NDIG_W     = $clog2(DIGITS + 1);
  localparam int CNT_W      = 6;
  localparam int CHAR_W     = 8;
  localparam int IN_W       = 48;

  localparam logic [CHAR_W-1:0] CHR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    SEL_SPACE,
    SEL_SIGN,
    SEL_ZERO,
    SEL_DIGIT
  } char_sel_e;

  typedef struct packed {
    logic              capture;
    logic              conv_step;
    logic              count;
    logic              size;
    logic              load;
    char_sel_e         sel;
    logic [NDIG_W-1:0] digit_idx;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic              out_free;
    logic              neg;
    logic [CNT_W-1:0]  sp_pre;
    logic [CNT_W-1:0]  zeros;
    logic [NDIG_W-1:0] ndig;
    logic [CNT_W-1:0]  sp_post;
    logic [CNT_W-1:0]  total;
  } sts_t;

endpackage

### hdl/sdff_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdff_datapath: conversion and character datapath
// Double-dabble binary to BCD, digit count, field sizing, output register.
// ----------------------------------------------------------------------------
module sdff_datapath
  import sdff_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_BITS-1:0]  value_i,
  input  logic [5:0]             field_width_i,
  input  logic [6:0]             precision_i,
  input  logic                   has_precision_i,
  input  logic                   zero_pad_i,
  input  logic                   left_align_i,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [CHAR_W-1:0]      out_char_o,
  output logic                   out_last_o
);

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [DIGITS*4-1:0]   bcd_q, bcd_d;
  logic                  neg_q, pvalid_q, zpad_q, left_q;
  logic [CNT_W-1:0]      width_q, prec_q;
  logic [NDIG_W-1:0]     ndig_q, ndig_d;
  logic [CNT_W-1:0]      sp_pre_q, sp_pre_d, zeros_q, zeros_d;
  logic [CNT_W-1:0]      sp_post_q, sp_post_d, total_q, total_d;
  logic                  out_valid_q;
  logic [CHAR_W-1:0]     out_char_q, out_char_d;
  logic                  out_last_q;

  logic                  in_neg, in_pvalid;
  logic [VALUE_BITS-1:0] in_mag;
  logic [CNT_W-1:0]      in_width, in_prec;
  logic [DIGITS*4-1:0]   bcd_adj;
  logic [CNT_W-1:0]      ndig6, lead, pad;
  logic [CNT_W:0]        len7, total7;
  logic [3:0]            digit;

  // input capture: magnitude, saturated width and precision
  always_comb begin
    in_neg    = value_i[VALUE_BITS-1];
    in_mag    = in_neg ? (~value_i + 1'b1) : value_i;
    in_pvalid = has_precision_i && !precision_i[6];
    in_width  = (field_width_i > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : field_width_i;
    if (!in_pvalid) begin
      in_prec = '0;
    end else if (precision_i[5:0] > CNT_W'(MAX_FIELD)) begin
      in_prec = CNT_W'(MAX_FIELD);
    end else begin
      in_prec = precision_i[5:0];
    end
  end

  // one double-dabble step: add three to each digit of five or more, shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? (bcd_q[i*4 +: 4] + 4'd3)
                                                    : bcd_q[i*4 +: 4];
    end
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (cmd_i.capture) begin
      bin_d = in_mag;
      bcd_d = '0;
    end else if (cmd_i.conv_step) begin
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      bcd_d = {bcd_adj[DIGITS*4-2:0], bin_q[VALUE_BITS-1]};
    end
  end

  // digit count; zero with precision zero has none
  always_comb begin
    ndig_d = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] != 4'd0) begin
        ndig_d = NDIG_W'(i + 1);
      end
    end
    if (ndig_d == '0 && !(pvalid_q && prec_q == '0)) begin
      ndig_d = NDIG_W'(1);
    end
  end

  // field sizing
  always_comb begin
    ndig6     = CNT_W'(ndig_q);
    lead      = (prec_q > ndig6) ? (prec_q - ndig6) : '0;
    len7      = {1'b0, lead} + {1'b0, ndig6} + {{CNT_W{1'b0}}, neg_q};
    pad       = ({1'b0, width_q} > len7) ? CNT_W'({1'b0, width_q} - len7) : '0;
    sp_pre_d  = (!left_q && !zpad_q) ? pad : '0;
    zeros_d   = (zpad_q ? pad : '0) + lead;
    sp_post_d = left_q ? pad : '0;
    total7    = {1'b0, pad} + len7;
    total_d   = total7[CNT_W-1:0];
  end

  always_comb begin
    digit = bcd_q[cmd_i.digit_idx*4 +: 4];
    case (cmd_i.sel)
      SEL_SPACE: out_char_d = CHR_SPACE;
      SEL_SIGN:  out_char_d = CHR_MINUS;
      SEL_ZERO:  out_char_d = CHR_ZERO;
      SEL_DIGIT: out_char_d = CHR_ZERO + {4'd0, digit};
      default:   out_char_d = CHR_SPACE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    if (cmd_i.capture) begin
      neg_q    <= in_neg;
      pvalid_q <= in_pvalid;
      zpad_q   <= zero_pad_i && !left_align_i && !in_pvalid;
      left_q   <= left_align_i;
      width_q  <= in_width;
      prec_q   <= in_prec;
    end
    if (cmd_i.count) begin
      ndig_q <= ndig_d;
    end
    if (cmd_i.size) begin
      sp_pre_q  <= sp_pre_d;
      zeros_q   <= zeros_d;
      sp_post_q <= sp_post_d;
      total_q   <= total_d;
    end
    if (cmd_i.load) begin
      out_char_q <= out_char_d;
      out_last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.neg      = neg_q;
  assign sts_o.sp_pre   = sp_pre_q;
  assign sts_o.zeros    = zeros_q;
  assign sts_o.ndig     = ndig_q;
  assign sts_o.sp_post  = sp_post_q;
  assign sts_o.total    = total_q;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

### hdl/sdff_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdff_ctrl: sequencing state machine
// Steps conversion, sizing, then walks the field segments one character a time.
// ----------------------------------------------------------------------------
module sdff_ctrl
  import sdff_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_CONV   = 10'b0000000010,
    ST_NDIG   = 10'b0000000100,
    ST_SIZE   = 10'b0000001000,
    ST_PLAN   = 10'b0000010000,
    ST_SPPRE  = 10'b0000100000,
    ST_SIGN   = 10'b0001000000,
    ST_ZERO   = 10'b0010000000,
    ST_DIGIT  = 10'b0100000000,
    ST_SPPOST = 10'b1000000000
  } state_e;

  state_e           state_q, state_d, seg_state;
  logic [CNT_W-1:0] cnt_q, cnt_d, rem_q, rem_d, seg_cnt;
  logic [4:0]       nonempty, after, nxt;

  // segment order: leading spaces, sign, zeros, digits, trailing spaces
  always_comb begin
    nonempty = {sts_i.sp_post != '0, sts_i.ndig != '0, sts_i.zeros != '0,
                sts_i.neg, sts_i.sp_pre != '0};
    case (state_q)
      ST_PLAN:   after = 5'b11111;
      ST_SPPRE:  after = 5'b11110;
      ST_SIGN:   after = 5'b11100;
      ST_ZERO:   after = 5'b11000;
      ST_DIGIT:  after = 5'b10000;
      default:   after = 5'b00000;
    endcase
    nxt = nonempty & after;
    if (nxt[0]) begin
      seg_state = ST_SPPRE;
      seg_cnt   = sts_i.sp_pre;
    end else if (nxt[1]) begin
      seg_state = ST_SIGN;
      seg_cnt   = CNT_W'(1);
    end else if (nxt[2]) begin
      seg_state = ST_ZERO;
      seg_cnt   = sts_i.zeros;
    end else if (nxt[3]) begin
      seg_state = ST_DIGIT;
      seg_cnt   = CNT_W'(sts_i.ndig);
    end else if (nxt[4]) begin
      seg_state = ST_SPPOST;
      seg_cnt   = sts_i.sp_post;
    end else begin
      seg_state = ST_IDLE;
      seg_cnt   = '0;
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    rem_d         = rem_q;
    cmd_o         = '0;
    cmd_o.sel     = SEL_SPACE;
    cmd_o.digit_idx = cnt_q[NDIG_W-1:0] - NDIG_W'(1);
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cnt_d         = CNT_W'(VALUE_BITS - 1);
          state_d       = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        cnt_d           = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_NDIG;
        end
      end
      ST_NDIG: begin
        cmd_o.count = 1'b1;
        state_d     = ST_SIZE;
      end
      ST_SIZE: begin
        cmd_o.size = 1'b1;
        state_d    = ST_PLAN;
      end
      ST_PLAN: begin
        rem_d   = sts_i.total;
        cnt_d   = seg_cnt;
        state_d = seg_state;
      end
      ST_SPPRE, ST_SIGN, ST_ZERO, ST_DIGIT, ST_SPPOST: begin
        case (state_q)
          ST_SIGN:  cmd_o.sel = SEL_SIGN;
          ST_ZERO:  cmd_o.sel = SEL_ZERO;
          ST_DIGIT: cmd_o.sel = SEL_DIGIT;
          default:  cmd_o.sel = SEL_SPACE;
        endcase
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.last = (rem_q == CNT_W'(1));
          rem_d      = rem_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_d = seg_state;
            cnt_d   = seg_cnt;
          end else begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
    end
  end

endmodule

### hdl/signed_decimal_field_formatter.sv
`timescale 1ns / 1ps
// Sequence: a taken request is converted to BCD by the double-dabble loop, one step for each
//   of the VALUE_BITS (32) bits; the digit count, sizing and planning precede the first character.
// Throughput: one character per cycle while the consumer is ready; a request keeps the
//   input closed until its N characters (N at most 63, possibly none) have been loaded.
// Reset: rst_ni, asynchronous, active low; returns to idle with no character pending.
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter: printf %d conversion as a character stream
// Takes a signed value with width, precision and flags; emits the padded
// decimal text, one ASCII character per transfer, tlast on the final one.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter
  import sdff_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [31:0] value, [37:32] field_width, [44:38] precision, [45] has_precision,
  // [46] zero_pad, [47] left_align
  input  logic [IN_W-1:0]   s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // [7:0] out_char
  output logic [CHAR_W-1:0] m_axis_tdata_o,
  // last character of the request
  output logic              m_axis_tlast_o
);

  cmd_t cmd;
  sts_t sts;

  // Controller: accepts a request only when idle, then runs the BCD loop,
  // the digit count, the sizing and the segment walk.
  sdff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: holds the request, the BCD digits, segment lengths and the
  // output register that decouples the consumer's back-pressure.
  sdff_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .value_i         (s_axis_tdata_i[31:0]),
    .field_width_i   (s_axis_tdata_i[37:32]),
    .precision_i     (s_axis_tdata_i[44:38]),
    .has_precision_i (s_axis_tdata_i[45]),
    .zero_pad_i      (s_axis_tdata_i[46]),
    .left_align_i    (s_axis_tdata_i[47]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .out_char_o      (m_axis_tdata_o),
    .out_last_o      (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  // a taken request keeps the input closed for at least the conversion
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input reopened straight after a request");

  // a character is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("output register overwritten");

  // characters are only produced while a request is in progress
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !s_axis_tready_o)
    else $error("character loaded while idle");

  // output valid rises only after the controller has been busy with a request
  a_valid_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("output valid without a request");
`endif

endmodule

### bench/signed_decimal_field_formatter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter_tb: self-checking bench for the %d formatter
// Sends requests over the slave stream and predicts the padded decimal text
// for each one. Every character taken from the master stream, and its tlast,
// is checked against that text. Directed corner cases run first, then random
// requests under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter_tb;
  import sdff_pkg::*;

  // same layout as s_axis_tdata_i, value in the low bits
  typedef struct packed {
    logic              left_align;
    logic              zero_pad;
    logic              has_precision;
    logic signed [6:0] precision;
    logic [5:0]        field_width;
    logic signed [31:0] value;
  } fmt_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } fmt_char_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              req_valid = 1'b0;
  fmt_req_t          req_data = '0;
  logic              req_ready;
  logic              txt_valid;
  logic              txt_ready = 1'b0;
  logic [CHAR_W-1:0] txt_char;
  logic              txt_last;

  fmt_char_t expected_text[$];
  int        stall_pct = 0;
  int        errors = 0;
  int        chars_seen = 0;

  signed_decimal_field_formatter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(req_valid),
    .s_axis_tready_o(req_ready),
    .s_axis_tdata_i (req_data),
    .m_axis_tvalid_o(txt_valid),
    .m_axis_tready_i(txt_ready),
    .m_axis_tdata_o (txt_char),
    .m_axis_tlast_o (txt_last)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("signed_decimal_field_formatter_tb NOT OK");
    $finish;
  end

  // Expected text for one request, appended to expected_text.
  function automatic void format_decimal(input fmt_req_t r);
    logic              neg;
    logic              prec_ok;
    logic              zfill;
    logic [31:0]       mag;
    int                width;
    int                prec;
    int                lead;
    int                pad;
    logic [CHAR_W-1:0] digits[$];
    logic [CHAR_W-1:0] text[$];
    neg     = r.value[31];
    mag     = neg ? (~r.value + 32'd1) : r.value;
    prec_ok = r.has_precision && !r.precision[6];
    prec    = prec_ok ? int'(r.precision[5:0]) : 0;
    width   = int'(r.field_width);
    if (width > MAX_FIELD) width = MAX_FIELD;
    if (prec > MAX_FIELD) prec = MAX_FIELD;
    zfill   = r.zero_pad && !r.left_align && !prec_ok;
    // zero with an explicit precision of zero has no digits at all
    if (!(mag == 32'd0 && prec_ok && prec == 0)) begin
      do begin
        digits.push_front(CHR_ZERO + CHAR_W'(mag % 32'd10));
        mag = mag / 32'd10;
      end while (mag != 32'd0);
    end
    lead = (prec > digits.size()) ? prec - digits.size() : 0;
    pad  = width - (digits.size() + lead + (neg ? 1 : 0));
    if (pad < 0) pad = 0;
    if (!r.left_align && !zfill) repeat (pad) text.push_back(CHR_SPACE);
    if (neg) text.push_back(CHR_MINUS);
    if (zfill) repeat (pad) text.push_back(CHR_ZERO);
    repeat (lead) text.push_back(CHR_ZERO);
    foreach (digits[i]) text.push_back(digits[i]);
    if (r.left_align) repeat (pad) text.push_back(CHR_SPACE);
    foreach (text[i]) expected_text.push_back('{text[i], i == text.size() - 1});
  endfunction

  function automatic fmt_req_t mk_req(input int value, input int width, input int prec,
                                      input bit dot, input bit zero, input bit left);
    fmt_req_t r;
    r.value         = value;
    r.field_width   = 6'(width);
    r.precision     = 7'(prec);
    r.has_precision = dot;
    r.zero_pad      = zero;
    r.left_align    = left;
    return r;
  endfunction

  function automatic fmt_req_t rand_request();
    fmt_req_t    r;
    logic [31:0] v;
    case ($urandom_range(7))
      0, 1: v = $urandom;
      2: v = $urandom_range(20);
      3: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(1) == 1) v = ~v + 32'd1;
    r.value         = v;
    // mostly narrow fields, now and then up to the saturating sizes
    r.field_width   = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                               : 6'($urandom_range(12));
    case ($urandom_range(7))
      0: r.precision = 7'($urandom_range(127));
      1: r.precision = -7'sd1;
      default: r.precision = 7'($urandom_range(12));
    endcase
    r.has_precision = 1'($urandom_range(1));
    r.zero_pad      = 1'($urandom_range(1));
    r.left_align    = 1'($urandom_range(1));
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input fmt_req_t r, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk_i); while (!req_ready);
    format_decimal(r);
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall);
    stall_pct = stall;
    repeat (count) send_request(rand_request(), idle_pct);
  endtask

  task automatic test_directed_cases();
    stall_pct = 0;
    send_request(mk_req(0, 0, -1, 0, 0, 0), 0);
    send_request(mk_req(0, 0, 0, 1, 0, 0), 0);             // no characters at all
    send_request(mk_req(0, 5, 0, 1, 0, 0), 0);             // padding only
    send_request(mk_req(0, 4, 0, 1, 1, 1), 0);
    send_request(mk_req(32'h7FFF_FFFF, 0, -1, 0, 0, 0), 0);
    send_request(mk_req(32'h8000_0000, 0, -1, 0, 0, 0), 0);
    send_request(mk_req(32'h8000_0000, 63, -1, 0, 1, 0), 0);
    send_request(mk_req(-1, 62, -1, 0, 0, 1), 0);
    send_request(mk_req(-42, 8, -1, 0, 1, 0), 0);          // sign ahead of zeros
    send_request(mk_req(-42, 8, -1, 0, 1, 1), 0);          // zero flag loses to left
    send_request(mk_req(42, 8, 5, 1, 1, 0), 0);            // zero flag loses to precision
    send_request(mk_req(42, 8, -1, 1, 1, 0), 0);           // dot with negative precision
    send_request(mk_req(42, 8, -64, 1, 1, 0), 0);
    send_request(mk_req(42, 8, 5, 0, 1, 0), 0);            // precision without dot
    send_request(mk_req(-7, 0, 63, 1, 0, 0), 0);
    send_request(mk_req(123, 0, 62, 1, 0, 1), 0);
    send_request(mk_req(32'h8000_0000, 63, 63, 1, 0, 0), 0); // longest field
    send_request(mk_req(0, 63, -1, 0, 0, 1), 0);
    send_request(mk_req(1000000000, 11, -1, 0, 0, 0), 0);
    send_request(mk_req(-999, 2, 1, 1, 0, 0), 0);
    send_request(mk_req(5, 1, 0, 1, 0, 0), 0);
    send_request(mk_req(-5, 3, -1, 0, 0, 0), 0);
  endtask

  task automatic test_back_to_back();
    run_random(90, 0, 0);
  endtask

  task automatic test_sparse_requests();
    run_random(90, 85, 0);
  endtask

  task automatic test_slow_consumer();
    run_random(90, 0, 85);
  endtask

  task automatic test_light_idling();
    run_random(90, 8, 8);
  endtask

  // consumer side: random stalls and the character check
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      txt_ready <= 1'b0;
    end else begin
      txt_ready <= ($urandom_range(99) >= stall_pct);
      if (txt_valid && txt_ready) begin
        fmt_char_t exp_c;
        chars_seen++;
        if (expected_text.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected character %02h last %0b at character %0d",
                     txt_char, txt_last, chars_seen);
        end else begin
          exp_c = expected_text.pop_front();
          if (txt_char !== exp_c.ch || txt_last !== exp_c.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at character %0d: expected %02h last %0b, got %02h last %0b",
                       chars_seen, exp_c.ch, exp_c.last, txt_char, txt_last);
          end
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_back_to_back();
    test_sparse_requests();
    test_slow_consumer();
    test_light_idling();
    req_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk_i);
    // room for anything the block should not have sent
    repeat (120) @(posedge clk_i);
    if (errors == 0 && expected_text.size() == 0) begin
      $display("signed_decimal_field_formatter_tb OK");
    end else begin
      $display("signed_decimal_field_formatter_tb NOT OK");
    end
    $finish;
  end

endmodule

### signed_decimal_field_formatter.f
hdl/sdff_pkg.sv
hdl/sdff_datapath.sv
hdl/sdff_ctrl.sv
hdl/signed_decimal_field_formatter.sv
bench/signed_decimal_field_formatter_tb.sv
